### design/assert_macros.svh
// Assertion macros shared by the transcoder RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define U8_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define U8_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define U8_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder: widths, byte patterns,
// the result item type and small counter helpers. No dependencies.
package u8u16_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int PART_W      = 21;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0]  CONT_MASK  = 8'hC0;
	localparam logic [7:0]  CONT_TAG   = 8'h80;
	localparam logic [7:0]  LEAD2_MASK = 8'hE0;
	localparam logic [7:0]  LEAD2_TAG  = 8'hC0;
	localparam logic [7:0]  LEAD3_MASK = 8'hF0;
	localparam logic [7:0]  LEAD3_TAG  = 8'hE0;
	localparam logic [7:0]  LEAD4_MASK = 8'hF8;
	localparam logic [7:0]  LEAD4_TAG  = 8'hF0;
	localparam logic [7:0]  PAYLOAD6   = 8'h3F;

	localparam logic [15:0]       REPLACEMENT = 16'hFFFD;
	localparam logic [15:0]       HI_SURR     = 16'hD800;
	localparam logic [15:0]       LO_SURR     = 16'hDC00;
	localparam logic [PART_W-1:0] SUPP_BASE   = 21'h10000;
	localparam logic [PART_W-1:0] LOW10_MASK  = 21'h003FF;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [PART_W-1:0]      partial_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
		logic [15:0] units_emitted;
	} unit_t;

	// Increment that holds at the all-ones value.
	function automatic count_t cnt_sat_inc(input count_t c);
		count_t r;
		r = (c == '1) ? c : count_t'(c + 1'b1);
		return r;
	endfunction

	// The reported count is the counter, clipped to sixteen bits.
	function automatic logic [15:0] cnt_to_units(input count_t c);
		logic [31:0] wide;
		wide = 32'(c);
		return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
	endfunction

endpackage

### design/u8u16_if.sv
// Valid/ready channel interfaces for the transcoder: the byte stream in
// and the code unit stream out. No dependencies.
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_unit;
	logic [15:0] units_emitted;

	modport source(output valid, code_unit, last_unit, units_emitted, input ready);
	modport sink(input valid, code_unit, last_unit, units_emitted, output ready);
endinterface

### design/utf8_to_utf16_decoder.sv
// A transferred byte is registered in the input stage, decoded from there into the
// output queue once the queue has room, and its first code unit is offered from the queue.
// Throughput: one byte per cycle; a surrogate pair fills two queue entries, and the
// four-entry output queue stalls the input when it has fewer than two free slots.
// Reset (arst_n low, asynchronous) empties the pipeline and the queue and clears the
// partial code point, the pending byte count and the unit counter.
`include "assert_macros.svh"

module utf8_to_utf16_decoder (
	input logic               clk,
	input logic               arst_n,
	u8u16_byte_if.sink        bytes,
	u8u16_unit_if.source      units
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Decoder state.
	u8u16_pkg::partial_t partial_q;
	logic [1:0]          expected_q;
	u8u16_pkg::count_t   counter_q;

	// Output queue.
	u8u16_pkg::unit_t                      fifo_q [u8u16_pkg::FIFO_DEPTH];
	logic [u8u16_pkg::FIFO_PTR_W-1:0]      wr_ptr_q;
	logic [u8u16_pkg::FIFO_PTR_W-1:0]      rd_ptr_q;
	logic [u8u16_pkg::FIFO_CNT_W-1:0]      count_q;

	logic advance;
	logic pop;

	// Decode results.
	logic                pending;
	logic                is_cont;
	u8u16_pkg::partial_t ext_p;
	u8u16_pkg::partial_t supp_v;
	u8u16_pkg::partial_t lead_p;
	logic [1:0]          lead_e;
	logic                lead_v;
	logic [1:0]          exp_dec;
	logic                a_v, b_v;
	logic [15:0]         a_code, b_code;
	logic                a_last, b_last;
	u8u16_pkg::partial_t next_p;
	logic [1:0]          next_e;
	u8u16_pkg::count_t   cnt1, cnt2, next_cnt;
	logic [1:0]          n_units;
	u8u16_pkg::unit_t    u0, u1;

	assign advance     = valid_s1 &&
		(count_q <= u8u16_pkg::FIFO_CNT_W'(u8u16_pkg::FIFO_DEPTH - 2));
	assign bytes.ready = !valid_s1 || advance;
	assign pop         = units.valid && units.ready;

	assign units.valid         = (count_q != '0);
	assign units.code_unit     = fifo_q[rd_ptr_q].code_unit;
	assign units.last_unit     = fifo_q[rd_ptr_q].last_unit;
	assign units.units_emitted = fifo_q[rd_ptr_q].units_emitted;

	always_comb begin
		pending = (expected_q != 2'd0);
		is_cont = ((byte_s1 & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG);
		ext_p   = {partial_q[14:0], byte_s1[5:0]};
		supp_v  = ext_p - u8u16_pkg::SUPP_BASE;
		exp_dec = expected_q - 2'd1;
		a_v     = 1'b0;
		a_code  = '0;
		a_last  = 1'b0;
		b_v     = 1'b0;
		b_code  = '0;
		b_last  = 1'b0;
		lead_p  = '0;
		lead_e  = 2'd0;
		lead_v  = 1'b0;
		next_p  = partial_q;
		next_e  = expected_q;

		if (pending && is_cont) begin
			if (exp_dec == 2'd0 || last_s1) begin
				if (ext_p >= u8u16_pkg::SUPP_BASE) begin
					// Supplementary plane: high surrogate first.
					a_v    = 1'b1;
					a_code = u8u16_pkg::HI_SURR + 16'(supp_v[20:10]);
					b_v    = 1'b1;
					b_code = u8u16_pkg::LO_SURR + 16'(supp_v & u8u16_pkg::LOW10_MASK);
					b_last = last_s1;
				end else begin
					a_v    = 1'b1;
					a_code = ext_p[15:0];
					a_last = last_s1;
				end
				next_p = '0;
				next_e = 2'd0;
			end else begin
				next_p = ext_p;
				next_e = exp_dec;
			end
		end else begin
			// An interrupted sequence is flushed as it stands; it always fits one unit.
			if (pending) begin
				a_v    = 1'b1;
				a_code = partial_q[15:0];
				next_p = '0;
				next_e = 2'd0;
			end
			priority if (!byte_s1[7]) begin
				b_v    = 1'b1;
				b_code = {8'h00, byte_s1};
				b_last = last_s1;
			end else if ((byte_s1 & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
				lead_v = 1'b1;
				lead_p = u8u16_pkg::PART_W'(byte_s1[4:0]);
				lead_e = 2'd1;
			end else if ((byte_s1 & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
				lead_v = 1'b1;
				lead_p = u8u16_pkg::PART_W'(byte_s1[3:0]);
				lead_e = 2'd2;
			end else if ((byte_s1 & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG) begin
				lead_v = 1'b1;
				lead_p = u8u16_pkg::PART_W'(byte_s1[2:0]);
				lead_e = 2'd3;
			end else begin
				b_v    = 1'b1;
				b_code = u8u16_pkg::REPLACEMENT;
				b_last = last_s1;
			end
			if (lead_v) begin
				if (last_s1) begin
					b_v    = 1'b1;
					b_code = lead_p[15:0];
					b_last = 1'b1;
				end else begin
					next_p = lead_p;
					next_e = lead_e;
				end
			end
		end

		if (last_s1) begin
			next_p = '0;
			next_e = 2'd0;
		end

		cnt1    = u8u16_pkg::cnt_sat_inc(counter_q);
		cnt2    = u8u16_pkg::cnt_sat_inc(cnt1);
		n_units = {1'b0, a_v} + {1'b0, b_v};

		u0.code_unit     = a_v ? a_code : b_code;
		u0.last_unit     = a_v ? a_last : b_last;
		u0.units_emitted = u8u16_pkg::cnt_to_units(cnt1);
		u1.code_unit     = b_code;
		u1.last_unit     = b_last;
		u1.units_emitted = u8u16_pkg::cnt_to_units(cnt2);

		unique case (n_units)
			2'd0:    next_cnt = counter_q;
			2'd1:    next_cnt = cnt1;
			default: next_cnt = cnt2;
		endcase
		if (last_s1) begin
			next_cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			partial_q  <= '0;
			expected_q <= 2'd0;
			counter_q  <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (advance) begin
				partial_q  <= next_p;
				expected_q <= next_e;
				counter_q  <= next_cnt;
				wr_ptr_q   <= wr_ptr_q + u8u16_pkg::FIFO_PTR_W'(n_units);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q
				+ (advance ? u8u16_pkg::FIFO_CNT_W'(n_units) : '0)
				- u8u16_pkg::FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
		if (advance) begin
			if (n_units != 2'd0) begin
				fifo_q[wr_ptr_q] <= u0;
			end
			if (n_units == 2'd2) begin
				fifo_q[wr_ptr_q + 1'b1] <= u1;
			end
		end
	end

	`U8_ASSERT(a_queue_bound, count_q <= u8u16_pkg::FIFO_CNT_W'(u8u16_pkg::FIFO_DEPTH), "output queue overflow")
	`U8_ASSERT_SAME(a_pending_fits, expected_q != 2'd0, partial_q < u8u16_pkg::SUPP_BASE, "pending value exceeds one unit")
	`U8_ASSERT_NEXT(a_last_clears, advance && last_s1, counter_q == '0 && expected_q == 2'd0, "string end did not clear state")
	`U8_ASSERT_NEXT(a_last_emits, advance && last_s1, count_q != '0, "string end produced no unit")

endmodule

### tb/testbench.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder utf8_to_utf16_decoder.
// Depends on u8u16_pkg, the u8u16_byte_if / u8u16_unit_if channel interfaces and the RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned STALL_LIMIT   = 1000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_BYTES  = 1200;
	localparam int unsigned LONG_BYTES    = 400;

	logic clk;
	logic arst_n;

	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	utf8_to_utf16_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch)
	);

	// Decoder state as predicted from the accepted byte stream.
	u8u16_pkg::partial_t acc_code  = '0;
	logic [1:0]          cont_left = '0;
	u8u16_pkg::count_t   str_units = '0;
	int unsigned         units_this_byte;
	u8u16_pkg::unit_t    predicted_units[$];

	int unsigned failures = 0;
	bit          gaps_on  = 1'b1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function void push_unit(input logic [15:0] value, input logic ends);
		u8u16_pkg::unit_t u;
		logic [31:0]      wide;
		if (units_this_byte >= 2)
			return;
		units_this_byte++;
		if (str_units != '1)
			str_units = str_units + 1'b1;
		wide = 32'(str_units);
		u.code_unit     = value;
		u.last_unit     = ends;
		u.units_emitted = (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
		predicted_units.push_back(u);
	endfunction

	// Code points above the basic plane go out as a high then a low surrogate.
	function void push_point(input u8u16_pkg::partial_t cp, input logic ends);
		u8u16_pkg::partial_t offset;
		if (cp >= u8u16_pkg::SUPP_BASE) begin
			offset = cp - u8u16_pkg::SUPP_BASE;
			push_unit(u8u16_pkg::HI_SURR + 16'(offset >> 10), 1'b0);
			push_unit(u8u16_pkg::LO_SURR + 16'(offset & u8u16_pkg::LOW10_MASK), ends);
		end else begin
			push_unit(cp[15:0], ends);
		end
	endfunction

	function void transcode_byte(input logic [7:0] value, input logic ends);
		units_this_byte = 0;
		if (cont_left != 0 && (value & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG) begin
			acc_code  = {acc_code[u8u16_pkg::PART_W-7:0], value[5:0]};
			cont_left = cont_left - 1'b1;
			if (cont_left == 0 || ends) begin
				push_point(acc_code, ends);
				cont_left = '0;
				acc_code  = '0;
			end
		end else begin
			// Any byte other than a continuation cuts short a pending sequence, which goes out as it stands.
			if (cont_left != 0) begin
				push_point(acc_code, 1'b0);
				cont_left = '0;
				acc_code  = '0;
			end
			if (!value[7]) begin
				push_point(u8u16_pkg::partial_t'(value), ends);
			end else if ((value & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
				acc_code  = u8u16_pkg::partial_t'(value[4:0]);
				cont_left = 2'd1;
			end else if ((value & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
				acc_code  = u8u16_pkg::partial_t'(value[3:0]);
				cont_left = 2'd2;
			end else if ((value & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG) begin
				acc_code  = u8u16_pkg::partial_t'(value[2:0]);
				cont_left = 2'd3;
			end else begin
				push_point(u8u16_pkg::partial_t'(u8u16_pkg::REPLACEMENT), ends);
			end
			if (cont_left != 0 && ends) begin
				push_point(acc_code, 1'b1);
				cont_left = '0;
				acc_code  = '0;
			end
		end
		if (ends) begin
			str_units = '0;
			acc_code  = '0;
			cont_left = '0;
		end
	endfunction

	// Valid stays high after a transfer so that back-to-back bytes need no gap.
	task automatic send_byte(input logic [7:0] value, input logic ends);
		int unsigned gap;
		logic        taken;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		repeat (gap) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= value;
		byte_ch.last_byte <= ends;
		do begin
			@(negedge clk);
			taken = (byte_ch.ready === 1'b1);
			if (taken)
				transcode_byte(value, ends);
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_string(input logic [7:0] text[$], input bit mark_end);
		foreach (text[i])
			send_byte(text[i], mark_end && (i == text.size() - 1));
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (predicted_units.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void encode_utf8(ref logic [7:0] text[$], input logic [20:0] cp,
			input int unsigned len, input int unsigned keep);
		logic [7:0] seq[4];
		case (len)
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			text.push_back(seq[i]);
	endfunction

	task automatic test_well_formed();
		send_string({8'h00, 8'h7F}, 1'b1);
		send_string({8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC}, 1'b0);
		send_string({8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b1);
		// Largest value that a four-byte form can carry, far beyond the Unicode range.
		send_string({8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b1);
	endtask

	task automatic test_invalid_bytes();
		send_string({8'h80, 8'hFF}, 1'b1);
	endtask

	task automatic test_interrupted_sequence();
		send_string({8'hE2, 8'h82, 8'h41}, 1'b1);
	endtask

	task automatic test_end_of_string();
		send_string({8'hC3}, 1'b1);
		send_string({8'hF0, 8'h9F, 8'h98}, 1'b1);
	endtask

	// One long string without gaps keeps a byte on the input in every cycle.
	task automatic test_long_string();
		gaps_on = 1'b0;
		for (int i = 0; i < LONG_BYTES; i++)
			send_byte(8'($urandom_range(0, 127)), i == LONG_BYTES - 1);
		wait_drained();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_text();
		logic [7:0]  text[$];
		logic [20:0] cp;
		int unsigned sent;
		int unsigned chars;
		int unsigned pick;
		int unsigned len;
		bit          paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_BYTES) begin
			text.delete();
			chars = $urandom_range(1, 12);
			repeat (chars) begin
				pick = $urandom_range(0, 99);
				cp   = 21'($urandom);
				if (pick < 35) begin
					text.push_back({1'b0, cp[6:0]});
				end else if (pick < 55) begin
					encode_utf8(text, cp, 2, 2);
				end else if (pick < 72) begin
					encode_utf8(text, cp, 3, 3);
				end else if (pick < 85) begin
					encode_utf8(text, cp, 4, 4);
				end else if (pick < 91) begin
					text.push_back(8'($urandom));
				end else if (pick < 96) begin
					len = $urandom_range(2, 4);
					encode_utf8(text, cp, len, $urandom_range(1, len - 1));
				end else begin
					text.push_back({2'b10, cp[5:0]});
				end
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			send_string(text, 1'b1);
			sent += text.size();
			if (!paused && sent >= RANDOM_BYTES / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin : unit_sink
		int unsigned hold;
		logic        taken;
		unit_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = gaps_on ? $urandom_range(0, 8) : 0;
			repeat (hold) begin
				unit_ch.ready <= 1'b0;
				@(posedge clk);
			end
			unit_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = (unit_ch.valid === 1'b1);
				@(posedge clk);
			end while (!taken);
		end
	end

	// Outputs are sampled at the falling edge, where they hold what the next rising
	// edge will transfer.
	always @(negedge clk) begin : unit_checker
		u8u16_pkg::unit_t want;
		if (arst_n === 1'b1 && unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1) begin
			if (predicted_units.size() == 0) begin
				$error("unexpected code unit %h", unit_ch.code_unit);
				failures++;
			end else begin
				want = predicted_units.pop_front();
				if (unit_ch.code_unit !== want.code_unit) begin
					$error("code_unit: expected %h, actual %h", want.code_unit,
						unit_ch.code_unit);
					failures++;
				end
				if (unit_ch.last_unit !== want.last_unit) begin
					$error("last_unit: expected %b, actual %b", want.last_unit,
						unit_ch.last_unit);
					failures++;
				end
				if (unit_ch.units_emitted !== want.units_emitted) begin
					$error("units_emitted: expected %0d, actual %0d", want.units_emitted,
						unit_ch.units_emitted);
					failures++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
					(unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("utf8_to_utf16_decoder regression: fail");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.last_byte = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_well_formed();
		test_invalid_bytes();
		test_interrupted_sequence();
		test_end_of_string();
		test_long_string();
		test_random_text();
		wait_drained();

		if (failures == 0)
			$display("utf8_to_utf16_decoder regression: pass");
		else
			$display("utf8_to_utf16_decoder regression: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/u8u16_pkg.sv
design/u8u16_if.sv
design/utf8_to_utf16_decoder.sv
tb/testbench.sv
